[sv/tea_pkg.sv]
package tea_pkg;

   // Command carried in the request tuser field.
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Result status carried in the response tuser field.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TRI_FULL   = 2'd1;
   localparam logic [1:0] ST_EDGE_FULL  = 2'd2;
   localparam logic [1:0] ST_NOT_LOADED = 2'd3;

   localparam int NUM_BITS  = 10;
   localparam int NB_BITS   = 11;
   localparam int QUERY_BITS = 10;
   localparam int RSP_BITS  = 48;

   localparam logic [NB_BITS-1:0] NB_NONE = 11'h7FF;

   // Multiplicative hash constants for the low and high vertex of an edge key.
   localparam logic [31:0] HASH_LO = 32'd2654435761;
   localparam logic [31:0] HASH_HI = 32'd40503;

endpackage

[sv/tea_hash.sv]
module tea_hash #(
   parameter int VB = 16,
   parameter int SW = 12
) (
   input  logic          clock,
   input  logic [VB-1:0] lo,
   input  logic [VB-1:0] hi,
   output logic [SW-1:0] pos
);

   // Only the low SW bits of each product reach the slot index, and those
   // depend only on the low SW bits of both operands.
   localparam logic [SW-1:0] KA = SW'(tea_pkg::HASH_LO);
   localparam logic [SW-1:0] KB = SW'(tea_pkg::HASH_HI);

   logic [SW-1:0] prod_a_ff;
   logic [SW-1:0] prod_b_ff;
   logic [SW-1:0] prod_a_in;
   logic [SW-1:0] prod_b_in;

   assign prod_a_in = SW'(lo) * KA;
   assign prod_b_in = SW'(hi) * KB;

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   assign pos = prod_a_ff ^ prod_b_ff;

endmodule

[sv/triangle_edge_adjacency_top.sv]
// From acceptance to rsp_tvalid: a load hashes and probes its edges in a counting pass
// and a storing pass, a query reads the stored corners and probes each edge, a clear
// writes every edge slot, and a full store, bad query or unknown command goes to the result.
// One item at a time; the probe loop through the edge table's read port sets the rate,
// and a result waits in the output register while the next item enters.
// Reset (synchronous, active high) clears the edge table slot by slot, req_tready low.
module triangle_edge_adjacency_top #(
   parameter int MAX_TRIANGLES = 1024,
   parameter int EDGE_SLOTS    = 4096,
   parameter int VERTEX_BITS   = 16,
   localparam int REQ_W = ((3 * VERTEX_BITS + tea_pkg::QUERY_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_a, vertex_b, vertex_c, query_index from the lowest bit up, zero padded.
   input  logic [REQ_W-1:0] req_tdata,
   // cmd.
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // triangle_number, neighbor_0, neighbor_1, neighbor_2 from the lowest bit up.
   output logic [tea_pkg::RSP_BITS-1:0] rsp_tdata,
   // status.
   output logic [1:0]       rsp_tuser
);

   localparam int VB  = VERTEX_BITS;
   localparam int CW  = $clog2(MAX_TRIANGLES);
   localparam int LCW = $clog2(MAX_TRIANGLES + 1);
   // The slot index is the hash taken modulo EDGE_SLOTS, which must be a power of two.
   localparam int SW  = $clog2(EDGE_SLOTS);
   localparam int UW  = SW + 1;
   localparam int NBW = tea_pkg::NB_BITS;
   localparam int NMW = tea_pkg::NUM_BITS;

   // One edge table slot: key pair, how many triangles are recorded, and the two triangles.
   typedef struct packed {
      logic          valid;
      logic [VB-1:0] lo;
      logic [VB-1:0] hi;
      logic [1:0]    count;
      logic [CW-1:0] tri_second;
      logic [CW-1:0] tri_first;
   } slot_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CORNER_RD, S_CORNER_WAIT, S_KEY, S_EDGE, S_HASH,
      S_POS, S_PROBE_RD, S_PROBE_CHK, S_NEXT, S_DONE
   } state_type;

   state_type           state_ff;
   logic [SW-1:0]       clr_cnt_ff;
   logic                clr_rsp_ff;
   logic                op_query_ff;
   logic                phase_ff;
   logic [1:0]          edge_ff;
   logic [1:0]          fresh_ff;
   logic [LCW-1:0]      loaded_ff;
   logic [UW-1:0]       used_ff;
   logic [SW-1:0]       pos_ff;
   logic [UW-1:0]       probe_n_ff;
   logic [NMW-1:0]      q_ff;
   logic [VB-1:0]       c_ff [3];
   logic [VB-1:0]       lo_ff [3];
   logic [VB-1:0]       hi_ff [3];
   logic [2:0]          dup_ff;
   logic [1:0]          res_status_ff;
   logic [NMW-1:0]      res_num_ff;
   logic [NBW-1:0]      nb_ff [3];
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [NMW-1:0]      rsp_num_ff;
   logic [NBW-1:0]      rsp_nb_ff [3];

   slot_type            edge_mem [EDGE_SLOTS];
   slot_type            edge_rd_ff;
   logic [3*VB-1:0]     corner_mem [MAX_TRIANGLES];
   logic [3*VB-1:0]     corner_rd_ff;

   logic                accept;
   logic [VB-1:0]       cur_lo;
   logic [VB-1:0]       cur_hi;
   logic [SW-1:0]       hash_pos;
   logic                match;
   logic                empty;
   logic                last_probe;
   logic [CW-1:0]       tnum;
   logic [CW-1:0]       qnum;
   slot_type            upd_slot;
   logic [NBW-1:0]      pick;
   logic                edge_we;
   logic [SW-1:0]       edge_wa;
   slot_type            edge_wd;
   logic                corner_we;
   logic [CW-1:0]       corner_ra;
   logic [VB-1:0]       key_lo [3];
   logic [VB-1:0]       key_hi [3];
   logic [UW:0]         need;
   logic [31:0]         q_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cur_lo = lo_ff[edge_ff];
   assign cur_hi = hi_ff[edge_ff];

   tea_hash #(.VB(VB), .SW(SW)) u_hash (
      .clock (clock),
      .lo    (cur_lo),
      .hi    (cur_hi),
      .pos   (hash_pos)
   );

   // Edge keys are unordered vertex pairs, kept as (smaller, larger).
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (c_ff[j] < c_ff[(j + 1) % 3]) begin
            key_lo[j] = c_ff[j];
            key_hi[j] = c_ff[(j + 1) % 3];
         end else begin
            key_lo[j] = c_ff[(j + 1) % 3];
            key_hi[j] = c_ff[j];
         end
      end
   end

   assign tnum       = CW'(loaded_ff);
   assign qnum       = CW'(q_ff);
   assign match      = edge_rd_ff.valid && edge_rd_ff.lo == cur_lo && edge_rd_ff.hi == cur_hi;
   assign empty      = !edge_rd_ff.valid;
   assign last_probe = (probe_n_ff == UW'(EDGE_SLOTS - 1));
   assign need       = (UW + 1)'(used_ff) + (UW + 1)'(fresh_ff);
   assign q_wide     = 32'(req_tdata[3*VB +: NMW]);

   // Slot after this load's triangle is recorded: a fresh slot starts empty, a triangle already
   // last on the edge (degenerate triangle) is not added again, and a slot with two is unchanged.
   always_comb begin
      upd_slot = edge_rd_ff;
      if (empty) begin
         upd_slot       = '0;
         upd_slot.valid = 1'b1;
         upd_slot.lo    = cur_lo;
         upd_slot.hi    = cur_hi;
      end
      if (upd_slot.count == 2'd0) begin
         upd_slot.tri_first = tnum;
         upd_slot.count     = 2'd1;
      end else if (upd_slot.count == 2'd1 && upd_slot.tri_first != tnum) begin
         upd_slot.tri_second = tnum;
         upd_slot.count      = 2'd2;
      end
   end

   // First recorded triangle on the edge other than the queried one.
   always_comb begin
      pick = tea_pkg::NB_NONE;
      if (edge_rd_ff.count != 2'd0 && edge_rd_ff.tri_first != qnum) begin
         pick = NBW'(edge_rd_ff.tri_first);
      end else if (edge_rd_ff.count == 2'd2 && edge_rd_ff.tri_second != qnum) begin
         pick = NBW'(edge_rd_ff.tri_second);
      end
   end

   always_comb begin
      edge_we = 1'b0;
      edge_wa = pos_ff;
      edge_wd = upd_slot;
      if (state_ff == S_CLEAR) begin
         edge_we = 1'b1;
         edge_wa = clr_cnt_ff;
         edge_wd = '0;
      end else if (state_ff == S_PROBE_CHK && !op_query_ff && phase_ff && (match || empty)) begin
         edge_we = 1'b1;
      end
   end

   assign corner_we = (state_ff == S_NEXT) && !op_query_ff && !phase_ff && (edge_ff == 2'd2)
                      && (need <= (UW + 1)'(EDGE_SLOTS));
   assign corner_ra = qnum;

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (corner_we) begin
         corner_mem[tnum] <= {c_ff[2], c_ff[1], c_ff[0]};
      end
      corner_rd_ff <= corner_mem[corner_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         loaded_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In S_DONE the output register is refilled directly, so it is not emptied here.
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == SW'(EDGE_SLOTS - 1)) begin
                  loaded_ff     <= '0;
                  used_ff       <= '0;
                  res_status_ff <= tea_pkg::ST_OK;
                  res_num_ff    <= '0;
                  for (int j = 0; j < 3; j++) nb_ff[j] <= tea_pkg::NB_NONE;
                  state_ff      <= clr_rsp_ff ? S_DONE : S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  for (int j = 0; j < 3; j++) nb_ff[j] <= tea_pkg::NB_NONE;
                  res_status_ff <= tea_pkg::ST_OK;
                  res_num_ff    <= '0;
                  phase_ff      <= 1'b0;
                  edge_ff       <= 2'd0;
                  fresh_ff      <= 2'd0;
                  q_ff          <= req_tdata[3*VB +: NMW];
                  c_ff[0]       <= req_tdata[0 +: VB];
                  c_ff[1]       <= req_tdata[VB +: VB];
                  c_ff[2]       <= req_tdata[2*VB +: VB];
                  unique case (tea_pkg::cmd_type'(req_tuser))
                     tea_pkg::CMD_LOAD: begin
                        op_query_ff <= 1'b0;
                        if (loaded_ff == LCW'(MAX_TRIANGLES)) begin
                           res_status_ff <= tea_pkg::ST_TRI_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_KEY;
                        end
                     end
                     tea_pkg::CMD_QUERY: begin
                        op_query_ff <= 1'b1;
                        res_num_ff  <= req_tdata[3*VB +: NMW];
                        if (q_wide >= 32'(loaded_ff) || q_wide >= 32'(MAX_TRIANGLES)) begin
                           res_status_ff <= tea_pkg::ST_NOT_LOADED;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_CORNER_RD;
                        end
                     end
                     tea_pkg::CMD_CLEAR: begin
                        clr_cnt_ff <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_CORNER_RD: begin
               state_ff <= S_CORNER_WAIT;
            end
            S_CORNER_WAIT: begin
               c_ff[0]  <= corner_rd_ff[0 +: VB];
               c_ff[1]  <= corner_rd_ff[VB +: VB];
               c_ff[2]  <= corner_rd_ff[2*VB +: VB];
               state_ff <= S_KEY;
            end
            S_KEY: begin
               for (int j = 0; j < 3; j++) begin
                  lo_ff[j] <= key_lo[j];
                  hi_ff[j] <= key_hi[j];
               end
               dup_ff[0] <= 1'b0;
               dup_ff[1] <= (key_lo[1] == key_lo[0]) && (key_hi[1] == key_hi[0]);
               dup_ff[2] <= ((key_lo[2] == key_lo[0]) && (key_hi[2] == key_hi[0]))
                            || ((key_lo[2] == key_lo[1]) && (key_hi[2] == key_hi[1]));
               state_ff  <= S_EDGE;
            end
            S_EDGE: begin
               // A repeated edge of a degenerate triangle is counted only once.
               if (!op_query_ff && !phase_ff && dup_ff[edge_ff]) begin
                  state_ff <= S_NEXT;
               end else begin
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               state_ff <= S_POS;
            end
            S_POS: begin
               pos_ff     <= hash_pos;
               probe_n_ff <= '0;
               state_ff   <= S_PROBE_RD;
            end
            S_PROBE_RD: begin
               state_ff <= S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
               if (match || empty || last_probe) begin
                  state_ff <= S_NEXT;
                  if (op_query_ff) begin
                     if (match) nb_ff[edge_ff] <= pick;
                  end else if (!phase_ff) begin
                     if (!match) fresh_ff <= fresh_ff + 1'b1;
                  end else if (empty) begin
                     used_ff <= used_ff + 1'b1;
                  end
               end else begin
                  pos_ff     <= pos_ff + 1'b1;
                  probe_n_ff <= probe_n_ff + 1'b1;
                  state_ff   <= S_PROBE_RD;
               end
            end
            S_NEXT: begin
               if (edge_ff != 2'd2) begin
                  edge_ff  <= edge_ff + 1'b1;
                  state_ff <= S_EDGE;
               end else if (op_query_ff) begin
                  state_ff <= S_DONE;
               end else if (!phase_ff) begin
                  // Counting pass done: either the whole triangle fits or nothing changes.
                  if (need > (UW + 1)'(EDGE_SLOTS)) begin
                     res_status_ff <= tea_pkg::ST_EDGE_FULL;
                     res_num_ff    <= NMW'(loaded_ff);
                     state_ff      <= S_DONE;
                  end else begin
                     phase_ff <= 1'b1;
                     edge_ff  <= 2'd0;
                     state_ff <= S_EDGE;
                  end
               end else begin
                  res_num_ff <= NMW'(loaded_ff);
                  loaded_ff  <= loaded_ff + 1'b1;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_num_ff    <= res_num_ff;
                  for (int j = 0; j < 3; j++) rsp_nb_ff[j] <= nb_ff[j];
                  clr_rsp_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_nb_ff[2], rsp_nb_ff[1], rsp_nb_ff[0], rsp_num_ff};

endmodule

[sv/tea_checker.sv]
module tea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A held result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Items are worked one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // Any failing status carries no neighbors.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tea_pkg::ST_OK |->
         rsp_tdata[20:10] == tea_pkg::NB_NONE && rsp_tdata[31:21] == tea_pkg::NB_NONE
         && rsp_tdata[42:32] == tea_pkg::NB_NONE)
      else $error("neighbor reported with failing status");

   // A full triangle store reports triangle number zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tea_pkg::ST_TRI_FULL |-> rsp_tdata[9:0] == 10'd0)
      else $error("store full result with nonzero number");

endmodule

bind triangle_edge_adjacency_top tea_checker u_tea_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
